// File: design/tracked_object_accel_estimator_unit_assert.svh
// Assertion macros for the tracked object acceleration estimator
`ifndef TRACKED_OBJECT_ACCEL_ESTIMATOR_UNIT_ASSERT_SVH
`define TRACKED_OBJECT_ACCEL_ESTIMATOR_UNIT_ASSERT_SVH
// assert that a implies b on the same edge
`define TOAE_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b on the next edge
`define TOAE_ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// File: design/toae_pkg.sv
// Package: types and constants for the acceleration estimator
package toae_pkg;
  localparam int ID_W = 31;
  localparam int V_W = 32;
  localparam int T_W = 32;
  localparam int AGE_CFG_W = 31;
  localparam int DV_W = 33;
  // dv * 1000 fits in 43 bits signed
  localparam int NUM_W = 43;
  localparam int QUO_W = 43;
  localparam logic [9:0] SCALE_K = 10'd1000;
  localparam logic [AGE_CFG_W-1:0] MAX_AGE_RST = 31'd1000;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b00000001,
    ST_SCAN   = 8'b00000010,
    ST_READ   = 8'b00000100,
    ST_DECIDE = 8'b00001000,
    ST_PREP   = 8'b00010000,
    ST_DIV    = 8'b00100000,
    ST_POST   = 8'b01000000,
    ST_DONE   = 8'b10000000
  } state_t;
endpackage

// File: design/tracked_object_accel_estimator_unit.sv
// Top level: tracked object acceleration estimator
// Usage: pulse start with an object word on in_* while busy is low; the word
// is taken on that edge and busy rises. The block scans its object table one
// entry per cycle, reads the hit entry from memory, then on a fresh hit runs
// three signed divisions by the age on one shared restoring divider, one
// quotient bit per cycle, with a setup and a writeback step per axis. The
// result word appears on out_* with out_strobe, which is high for a single
// cycle; busy drops at the edge that ends it. The block takes one word at a
// time: a new word is accepted only once busy is low again. The receiver
// cannot stall: out_strobe lasts one cycle.
// cfg_we writes max_age_ms; write only while busy is low.
// Reset (synchronous, rst_n low) clears all valid bits and the sequencer
// and loads max_age_ms with 1000; the table data stays undefined.
module tracked_object_accel_estimator_unit #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [toae_pkg::AGE_CFG_W-1:0] cfg_max_age_ms,
  input  logic start,
  output logic busy,
  input  logic [toae_pkg::ID_W-1:0] in_object_id,
  input  logic signed [toae_pkg::V_W-1:0] in_vel_x,
  input  logic signed [toae_pkg::V_W-1:0] in_vel_y,
  input  logic signed [toae_pkg::V_W-1:0] in_vel_z,
  input  logic signed [toae_pkg::T_W-1:0] in_now_ms,
  output logic out_strobe,
  output logic signed [toae_pkg::V_W-1:0] out_accel_x,
  output logic signed [toae_pkg::V_W-1:0] out_accel_y,
  output logic signed [toae_pkg::V_W-1:0] out_accel_z,
  output logic out_estimated,
  output logic out_dropped
);
  import toae_pkg::*;
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int DCW = $clog2(NUM_W + 1);

  state_t state_r, state_nxt;
  logic [AGE_CFG_W-1:0] max_age_r;
  logic [TABLE_ENTRIES-1:0] valid_r;

  // table memory: object id, velocities, time
  logic [ID_W-1:0] mem_id [TABLE_ENTRIES];
  logic [3*V_W+T_W-1:0] mem_dat [TABLE_ENTRIES];
  logic [ID_W-1:0] rd_id_r;
  logic [3*V_W+T_W-1:0] rd_dat_r;
  logic [IW-1:0] rd_addr;
  logic wr_en;
  logic [IW-1:0] wr_addr;

  logic [ID_W-1:0] id_r;
  logic [V_W-1:0] vx_r, vy_r, vz_r;
  logic [T_W-1:0] now_r;

  logic [CW-1:0] scan_r;
  logic scan_pend_r;   // read of scan_r-1 in flight
  logic [IW-1:0] pend_idx_r;
  logic hit_r, free_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;

  logic signed [T_W-1:0] age_r;
  logic [1:0] axis_r;
  logic [NUM_W-1:0] rem_r, quo_r, dvs_r;
  logic neg_r;
  logic [DCW-1:0] bit_r;
  logic signed [V_W-1:0] acc_r [3];
  logic est_r, drop_r;

  assign busy = !(state_r == ST_IDLE);
  assign out_strobe = (state_r == ST_DONE);
  assign out_accel_x = acc_r[0];
  assign out_accel_y = acc_r[1];
  assign out_accel_z = acc_r[2];
  assign out_estimated = est_r;
  assign out_dropped = drop_r;

  always_comb begin
    rd_addr = scan_r[IW-1:0];
    if (state_r == ST_READ) rd_addr = hit_idx_r;
  end

  // read data holds the hit entry from READ until the word is done
  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN || state_r == ST_READ) begin
      rd_id_r <= mem_id[rd_addr];
      rd_dat_r <= mem_dat[rd_addr];
    end
    if (wr_en) begin
      mem_id[wr_addr] <= id_r;
      mem_dat[wr_addr] <= {vx_r, vy_r, vz_r, now_r};
    end
  end

  // selected velocity component of the stored entry and of the new word
  logic signed [V_W-1:0] prev_v, cur_v;
  logic signed [DV_W-1:0] dv;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0] num_abs;
  logic [NUM_W:0] trial;
  logic signed [NUM_W:0] q_s;
  logic [V_W-1:0] sat;
  logic [T_W-1:0] age_abs;
  logic signed [T_W:0] age_ext;

  always_comb begin
    case (axis_r)
      2'd0: begin prev_v = rd_dat_r[T_W+3*V_W-1 -: V_W]; cur_v = vx_r; end
      2'd1: begin prev_v = rd_dat_r[T_W+2*V_W-1 -: V_W]; cur_v = vy_r; end
      default: begin prev_v = rd_dat_r[T_W+V_W-1 -: V_W]; cur_v = vz_r; end
    endcase
    dv = DV_W'(cur_v) - DV_W'(prev_v);
    num = NUM_W'(dv) * $signed({1'b0, SCALE_K});
    num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    age_abs = age_r[T_W-1] ? T_W'(-age_r) : T_W'(age_r);
    trial = {rem_r, quo_r[NUM_W-1]} - {1'b0, NUM_W'(age_abs)};
    q_s = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    if (q_s > $signed((NUM_W+1)'(32'h7FFFFFFF))) sat = 32'h7FFFFFFF;
    else if (q_s < -$signed((NUM_W+1)'(33'h080000000))) sat = 32'h80000000;
    else sat = q_s[V_W-1:0];
    age_ext = $signed({now_r[T_W-1], now_r}) - $signed({rd_dat_r[T_W-1], rd_dat_r[T_W-1:0]});
  end

  always_comb begin
    state_nxt = state_r;
    wr_en = 1'b0;
    wr_addr = hit_idx_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_r == CW'(TABLE_ENTRIES) && !scan_pend_r) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        state_nxt = ST_DONE;
        if (hit_r) begin
          wr_en = 1'b1;
          // signed age: a negative age counts as fresh
          if ($signed(T_W'(age_ext)) != 0 &&
              $signed(T_W'(age_ext)) < $signed({1'b0, max_age_r}))
            state_nxt = ST_PREP;
        end else if (free_r) begin
          wr_en = 1'b1;
          wr_addr = free_idx_r;
        end
      end
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV: if (bit_r == DCW'(NUM_W)) state_nxt = ST_POST;
      ST_POST: state_nxt = (axis_r == 2'd2) ? ST_DONE : ST_PREP;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      max_age_r <= MAX_AGE_RST;
      valid_r <= '0;
      scan_r <= '0;
      scan_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) max_age_r <= cfg_max_age_ms;
      if (wr_en) valid_r[wr_addr] <= 1'b1;
      case (state_r)
        ST_IDLE: begin
          scan_r <= '0;
          scan_pend_r <= 1'b0;
        end
        ST_SCAN: begin
          scan_pend_r <= (scan_r != CW'(TABLE_ENTRIES));
          if (scan_r != CW'(TABLE_ENTRIES)) scan_r <= scan_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        id_r <= in_object_id; vx_r <= in_vel_x; vy_r <= in_vel_y;
        vz_r <= in_vel_z; now_r <= in_now_ms;
        hit_r <= 1'b0; free_r <= 1'b0;
        hit_idx_r <= '0; free_idx_r <= '0;
        est_r <= 1'b0; drop_r <= 1'b0; axis_r <= 2'd0;
        acc_r[0] <= '0; acc_r[1] <= '0; acc_r[2] <= '0;
      end
      ST_SCAN: begin
        pend_idx_r <= scan_r[IW-1:0];
        if (scan_pend_r) begin
          if (valid_r[pend_idx_r]) begin
            if (!hit_r && rd_id_r == id_r) begin
              hit_r <= 1'b1; hit_idx_r <= pend_idx_r;
            end
          end else if (!free_r) begin
            free_r <= 1'b1; free_idx_r <= pend_idx_r;
          end
        end
      end
      ST_DECIDE: begin
        drop_r <= !hit_r && !free_r;
        age_r <= T_W'(age_ext);
      end
      ST_PREP: begin
        rem_r <= '0;
        quo_r <= num_abs;
        neg_r <= num[NUM_W-1] ^ age_r[T_W-1];
        bit_r <= '0;
      end
      ST_DIV: if (bit_r != DCW'(NUM_W)) begin
        bit_r <= bit_r + DCW'(1);
        if (!trial[NUM_W]) begin
          rem_r <= trial[NUM_W-1:0];
          quo_r <= {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[NUM_W-2:0], quo_r[NUM_W-1]};
          quo_r <= {quo_r[NUM_W-2:0], 1'b0};
        end
      end
      ST_POST: begin
        acc_r[axis_r] <= sat;
        axis_r <= axis_r + 2'd1;
        est_r <= 1'b1;
      end
      default: ;
    endcase
  end
endmodule

// File: design/toae_checker.sv
// Port checker for the acceleration estimator, bound to the top level
`include "tracked_object_accel_estimator_unit_assert.svh"
module toae_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_estimated,
  input logic out_dropped,
  input logic [31:0] out_accel_x
);
  `TOAE_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `TOAE_ASSERT_IMP(a_strobe_busy, clk, rst_n, out_strobe, busy)
  `TOAE_ASSERT_NXT(a_strobe_ends, clk, rst_n, out_strobe, !busy && !out_strobe)
  `TOAE_ASSERT_IMP(a_flags_excl, clk, rst_n, out_strobe, !(out_estimated && out_dropped))
  `TOAE_ASSERT_IMP(a_zero_acc, clk, rst_n, out_strobe && !out_estimated, out_accel_x == 32'd0)
endmodule

bind tracked_object_accel_estimator_unit toae_checker u_toae_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_estimated(out_estimated),
  .out_dropped(out_dropped), .out_accel_x(out_accel_x)
);

// File: sim/tracked_object_accel_estimator_unit_test.sv
// Testbench for the tracked object acceleration estimator unit
`timescale 1ns / 1ps

module tracked_object_accel_estimator_unit_test;
  import toae_pkg::*;

  localparam int SLOTS = 64;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct {
    logic [ID_W-1:0] id;
    logic signed [V_W-1:0] vx, vy, vz;
    logic signed [T_W-1:0] now;
  } det_word_t;

  typedef struct {
    logic signed [V_W-1:0] ax, ay, az;
    logic est, drop;
  } accel_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [AGE_CFG_W-1:0] cfg_max_age_ms = '0;
  logic start = 1'b0;
  logic busy;
  logic [ID_W-1:0] in_object_id = '0;
  logic signed [V_W-1:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic signed [T_W-1:0] in_now_ms = '0;
  logic out_strobe;
  logic signed [V_W-1:0] out_accel_x, out_accel_y, out_accel_z;
  logic out_estimated, out_dropped;

  tracked_object_accel_estimator_unit #(.TABLE_ENTRIES(SLOTS)) DUT (.*);

  initial forever #1 clk = ~clk;

  // predictor state
  logic [AGE_CFG_W-1:0] age_limit;
  logic trk_valid[SLOTS];
  logic [ID_W-1:0] trk_id[SLOTS];
  logic signed [V_W-1:0] trk_vx[SLOTS], trk_vy[SLOTS], trk_vz[SLOTS];
  logic signed [T_W-1:0] trk_time[SLOTS];

  det_word_t pending_dets[$];
  accel_word_t expected_accels[$];
  bit driver_quiet = 1'b0;
  int fail_count = 0;
  int est_count = 0, drop_count = 0, word_count = 0;
  longint cycles = 0;

  function automatic logic signed [V_W-1:0] axis_accel(logic signed [V_W-1:0] v_now,
      logic signed [V_W-1:0] v_prev, logic signed [T_W-1:0] age);
    longint dv, q;
    dv = longint'(v_now) - longint'(v_prev);
    q = (dv * 1000) / longint'(age);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic accel_word_t track_update(det_word_t d);
    accel_word_t r;
    int hit, free;
    logic signed [T_W-1:0] age;
    r = '{0, 0, 0, 1'b0, 1'b0};
    hit = -1;
    free = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (trk_valid[i]) begin
        if (hit < 0 && trk_id[i] == d.id) hit = i;
      end else if (free < 0) begin
        free = i;
      end
    end
    if (hit < 0 && free >= 0) hit = free;
    else if (hit < 0) r.drop = 1'b1;
    else begin
      age = d.now - trk_time[hit];
      if (age != 0 && longint'(age) < longint'({1'b0, age_limit})) begin
        r.ax = axis_accel(d.vx, trk_vx[hit], age);
        r.ay = axis_accel(d.vy, trk_vy[hit], age);
        r.az = axis_accel(d.vz, trk_vz[hit], age);
        r.est = 1'b1;
      end
    end
    if (hit >= 0) begin
      trk_valid[hit] = 1'b1;
      trk_id[hit] = d.id;
      trk_vx[hit] = d.vx;
      trk_vy[hit] = d.vy;
      trk_vz[hit] = d.vz;
      trk_time[hit] = d.now;
    end
    return r;
  endfunction

  // driver: idles about 32% unless quiet
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (start && !busy) begin
        expected_accels = {expected_accels, track_update(pending_dets.pop_front())};
        start <= 1'b0;
      end else if (!start && !busy && pending_dets.size() > 0 &&
                   (driver_quiet || $urandom_range(99) >= 32)) begin
        in_object_id <= pending_dets[0].id;
        in_vel_x <= pending_dets[0].vx;
        in_vel_y <= pending_dets[0].vy;
        in_vel_z <= pending_dets[0].vz;
        in_now_ms <= pending_dets[0].now;
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    accel_word_t e;
    if (rst_n && out_strobe) begin
      word_count++;
      if (expected_accels.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        e = expected_accels.pop_front();
        if (e.est) est_count++;
        if (e.drop) drop_count++;
        if (out_accel_x !== e.ax) begin
          $error("accel_x exp %0d got %0d", e.ax, out_accel_x); fail_count++;
        end
        if (out_accel_y !== e.ay) begin
          $error("accel_y exp %0d got %0d", e.ay, out_accel_y); fail_count++;
        end
        if (out_accel_z !== e.az) begin
          $error("accel_z exp %0d got %0d", e.az, out_accel_z); fail_count++;
        end
        if (out_estimated !== e.est) begin
          $error("estimated exp %0b got %0b", e.est, out_estimated); fail_count++;
        end
        if (out_dropped !== e.drop) begin
          $error("dropped exp %0b got %0b", e.drop, out_dropped); fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_det(logic [ID_W-1:0] id, logic signed [V_W-1:0] vx,
      logic signed [V_W-1:0] vy, logic signed [V_W-1:0] vz, logic signed [T_W-1:0] t);
    det_word_t d;
    d.id = id; d.vx = vx; d.vy = vy; d.vz = vz; d.now = t;
    pending_dets = {pending_dets, d};
  endtask

  task automatic drain();
    wait (pending_dets.size() == 0 && !start && expected_accels.size() == 0);
    repeat (SLOTS + 200) @(posedge clk);
  endtask

  task automatic write_age(logic [AGE_CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_max_age_ms <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    age_limit = v;
  endtask

  function automatic logic signed [V_W-1:0] rand_vel();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(400000)) - 200000;
    endcase
  endfunction

  initial begin
    logic signed [T_W-1:0] clock_ms;
    int base_id, n_obj;
    age_limit = MAX_AGE_RST;
    for (int i = 0; i < SLOTS; i++) trk_valid[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, fresh, zero age, negative age, stale
    push_det(31'h7fffffff, 32'sh7fffffff, 32'sh80000000, 0, 0);
    push_det(31'h7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh10000, 1);
    push_det(31'h7fffffff, 32'sh80000000, 0, 5, 1);
    push_det(31'h7fffffff, 32'sh00010000, 0, -5, -100);
    push_det(31'h7fffffff, 32'sh00020000, 3, -7, 900);
    push_det(31'h7fffffff, 32'sh00030000, 3, -7, 1900);
    push_det(0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    push_det(0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    push_det(0, 1, -1, 0, 32'sh80000001);
    drain();
    write_age(0);
    push_det(0, 100, 200, 300, 32'sh80000000);
    push_det(0, 100, 200, 300, 32'sh80000005);
    drain();
    write_age(31'h7fffffff);
    push_det(0, 32'sh7fffffff, 0, 0, 32'sh7ffffffe);
    push_det(5, 32'sh12345678, 0, 0, 10);
    push_det(5, -32'sh12345678, 0, 0, 32'sh7fffffff);
    // fill the table to force drops
    for (int i = 0; i < SLOTS + 3; i++) push_det(ID_W'(1000 + i), i, -i, 0, i);
    drain();
    write_age(1);
    push_det(1000, 7, 7, 7, 100);
    drain();
    // random: table reset via fresh ids impossible; reuse slots by id pool
    clock_ms = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_age(1000);
        1: write_age(31'h7fffffff);
        2: write_age(50);
        3: write_age(AGE_CFG_W'($urandom_range(1, 5000)));
        4: write_age(1);
        default: write_age(MAX_AGE_RST);
      endcase
      driver_quiet = (ph == 2);
      base_id = 1000 + $urandom_range(SLOTS + 10);
      n_obj = (ph == 4) ? SLOTS + 10 : $urandom_range(4, 40);
      for (int k = 0; k < 320; k++) begin
        if ($urandom_range(9) == 0) begin
          push_det(ID_W'($urandom), $urandom, $urandom, $urandom, $urandom);
        end else begin
          clock_ms = clock_ms + $signed($urandom_range(60)) - 5;
          push_det(ID_W'(base_id + $urandom_range(n_obj - 1)), rand_vel(), rand_vel(),
                   rand_vel(), clock_ms);
        end
      end
      drain();
    end
    driver_quiet = 1'b0;

    $display("%0d words checked: %0d estimates, %0d dropped inserts, six age settings",
             word_count, est_count, drop_count);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// File: tracked_object_accel_estimator_unit.f
+incdir+design
design/toae_pkg.sv
design/tracked_object_accel_estimator_unit.sv
design/toae_checker.sv
sim/tracked_object_accel_estimator_unit_test.sv
